// ===== rtl/integrate_and_fire_aggregator_defines.svh =====
// Assertion macros shared by the integrate-and-fire aggregator RTL.
`ifndef INTEGRATE_AND_FIRE_AGGREGATOR_DEFINES_SVH
`define INTEGRATE_AND_FIRE_AGGREGATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define IAF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integrate_and_fire_aggregator: assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define IAF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integrate_and_fire_aggregator: assertion failed");
`else
`define IAF_ASSERT_IMP(label, clk, rst, ante, cons)
`define IAF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/iaf_pkg.sv =====
// Package with sizes, types and helper functions of the integrate-and-fire aggregator.
`default_nettype none
package iaf_pkg;

   localparam int HIDDEN_SIZE = 256;
   localparam int POS_W       = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;

   typedef logic [15:0]          weight_type;
   typedef logic signed [15:0]   value_type;
   typedef logic signed [31:0]   sum_type;
   typedef logic [POS_W-1:0]     pos_type;
   typedef logic signed [16:0]   integral_type;
   typedef logic signed [17:0]   part_type;
   typedef logic signed [18:0]   integral_wide_type;
   typedef logic signed [33:0]   product_type;
   typedef logic signed [34:0]   acc_wide_type;

   localparam integral_wide_type ONE_Q15      = 19'sd32768;
   localparam integral_wide_type INTEGRAL_MAX = 19'sd65535;
   localparam integral_wide_type INTEGRAL_MIN = -19'sd65536;
   localparam acc_wide_type      SUM_MAX      = 35'sd2147483647;
   localparam acc_wide_type      SUM_MIN      = -35'sd2147483648;

   // Clamp a widened sum to the signed 32-bit range.
   function automatic sum_type sat32(input acc_wide_type x);
      sum_type r;
      if (x > SUM_MAX) begin
         r = sum_type'(SUM_MAX);
      end else if (x < SUM_MIN) begin
         r = sum_type'(SUM_MIN);
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/iaf_channels.sv =====
// Handshake channel interfaces for element input, token output and threshold writes.
`default_nettype none
interface iaf_req_if;
   import iaf_pkg::*;
   logic       valid;
   logic       ready;
   weight_type weight;
   value_type  value;
   logic       frame_end;
   modport source (output valid, output weight, output value, output frame_end,
                   input ready);
   modport sink   (input valid, input weight, input value, input frame_end,
                   output ready);
endinterface

interface iaf_rsp_if;
   import iaf_pkg::*;
   logic    valid;
   logic    ready;
   sum_type sum;
   logic    token_end;
   modport source (output valid, output sum, output token_end, input ready);
   modport sink   (input valid, input sum, input token_end, output ready);
endinterface

interface iaf_csr_if;
   import iaf_pkg::*;
   logic       valid;
   logic       ready;
   weight_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/integrate_and_fire_aggregator.sv =====
// Top level of the integrate-and-fire aggregator: integral update, accumulator store, output.
// An element is registered in the work stage; a firing one then loads its sum into rsp.
// Throughput: one element per cycle unless the output stalls; the accumulator RMW is the loop.
// Reset clears the integral, position, fire state and all accumulator valid bits.
// There is no clearing pass: an entry whose valid bit is clear reads as zero.
`default_nettype none
`include "integrate_and_fire_aggregator_defines.svh"
module integrate_and_fire_aggregator (
   input wire logic  clock,
   input wire logic  reset,
   iaf_req_if.sink   req_if,
   iaf_rsp_if.source rsp_if,
   iaf_csr_if.sink   csr_if
);
   import iaf_pkg::*;

   // Threshold register. Writes must come only while the block is idle; the
   // block does not enforce this, and the port is always ready.
   weight_type threshold_ff;

   // Frame state. The integral and the used/carry parts change only at the
   // first element of a frame; the element in the work stage reads them
   // directly, because the next frame start cannot be accepted before that
   // element leaves the stage.
   integral_type integral_ff, integral_in;
   pos_type      pos_ff, pos_in;
   logic         fires_ff, fires_in;
   part_type     used_ff, used_in;
   part_type     carry_ff, carry_in;

   // Work stage: the accepted element plus the registered RAM read.
   logic      s1_valid_ff;
   pos_type   s1_pos_ff;
   value_type s1_value_ff;
   logic      s1_last_ff;

   // Accumulator store with one valid bit per entry so that reset is immediate.
   sum_type   acc_mem [HIDDEN_SIZE];
   logic      acc_vld_ff [HIDDEN_SIZE];
   sum_type   rd_data_ff;
   logic      rd_vld_ff;
   // Forwarding of a write that hits the address read in the same cycle.
   logic      fwd_ff;
   sum_type   fwd_data_ff;

   // Output register.
   logic      rsp_valid_ff;
   sum_type   rsp_sum_ff;
   logic      rsp_last_ff;

   logic              req_accept;
   logic              out_free;
   logic              s1_advance;
   integral_wide_type completion;
   integral_wide_type next_int;
   logic              new_fires;
   sum_type           old_acc;
   product_type       used_prod;
   product_type       carry_prod;
   sum_type           new_sum;
   sum_type           restart_sum;
   sum_type           wr_data;

   assign csr_if.ready = 1'b1;

   // The work stage moves on unless it must emit and the output is still full.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_advance   = s1_valid_ff && (!fires_ff || out_free);
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_accept   = req_if.valid && req_if.ready;

   // Integral update, fire decision and used/carry parts for the first element of a frame.
   always_comb begin
      completion = ONE_Q15 - 19'(integral_ff);
      next_int   = 19'(integral_ff) + 19'(signed'({1'b0, req_if.weight}));
      new_fires  = next_int >= 19'(signed'({1'b0, threshold_ff}));
      integral_in = integral_ff;
      fires_in    = fires_ff;
      used_in     = used_ff;
      carry_in    = carry_ff;
      if (req_accept && (pos_ff == '0)) begin
         fires_in = new_fires;
         if (new_fires) begin
            next_int = next_int - ONE_Q15;
            used_in  = 18'(completion);
            carry_in = 18'(19'(signed'({1'b0, req_if.weight})) - completion);
         end else begin
            used_in  = 18'(signed'({1'b0, req_if.weight}));
            carry_in = '0;
         end
         if (next_int > INTEGRAL_MAX) begin
            integral_in = 17'(INTEGRAL_MAX);
         end else if (next_int < INTEGRAL_MIN) begin
            integral_in = 17'(INTEGRAL_MIN);
         end else begin
            integral_in = next_int[16:0];
         end
      end
   end

   // Position within the frame; a frame end or the last slot wraps to zero.
   always_comb begin
      pos_in = pos_ff;
      if (req_accept) begin
         if (req_if.frame_end || (pos_ff == POS_W'(HIDDEN_SIZE - 1))) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // Multiply-accumulate on the work-stage element's entry, or a carry restart on a fire.
   always_comb begin
      if (fwd_ff) begin
         old_acc = fwd_data_ff;
      end else if (rd_vld_ff) begin
         old_acc = rd_data_ff;
      end else begin
         old_acc = '0;
      end
      used_prod   = 34'(used_ff) * 34'(s1_value_ff);
      carry_prod  = 34'(carry_ff) * 34'(s1_value_ff);
      new_sum     = sat32(35'(old_acc) + 35'(used_prod));
      restart_sum = sat32(35'(carry_prod));
      wr_data     = fires_ff ? restart_sum : new_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= weight_type'(ONE_Q15);
         integral_ff  <= '0;
         pos_ff       <= '0;
         fires_ff     <= 1'b0;
         used_ff      <= '0;
         carry_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            threshold_ff <= csr_if.data;
         end
         integral_ff <= integral_in;
         pos_ff      <= pos_in;
         fires_ff    <= fires_in;
         used_ff     <= used_in;
         carry_ff    <= carry_in;
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= s1_advance && (s1_pos_ff == pos_ff);
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
            fwd_ff      <= 1'b0;
         end
         if (s1_advance && fires_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers of the work stage and the output.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pos_ff   <= pos_ff;
         s1_value_ff <= req_if.value;
         s1_last_ff  <= req_if.frame_end;
         fwd_data_ff <= wr_data;
      end
      if (s1_advance && fires_ff) begin
         rsp_sum_ff  <= new_sum;
         rsp_last_ff <= s1_last_ff;
      end
   end

   // Accumulator RAM: one registered read at accept, one write as an element leaves.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= acc_mem[pos_ff];
      end
      if (s1_advance) begin
         acc_mem[s1_pos_ff] <= wr_data;
      end
   end

   // Valid bits of the accumulator entries.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIDDEN_SIZE; i++) begin
            acc_vld_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            rd_vld_ff <= acc_vld_ff[pos_ff];
         end
         if (s1_advance) begin
            acc_vld_ff[s1_pos_ff] <= 1'b1;
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.sum       = rsp_sum_ff;
   assign rsp_if.token_end = rsp_last_ff;

   // A new result is loaded only by a firing element leaving the work stage.
   `IAF_ASSERT_IMP(a_rsp_load_src, clock, reset, $rose(rsp_valid_ff), $past(s1_advance && fires_ff))
   // The integral moves only at the first element of a frame.
   `IAF_ASSERT_NXT(a_integral_hold, clock, reset, req_accept && (pos_ff != '0), $stable(integral_ff))
   // A frame end always returns the position to the first slot.
   `IAF_ASSERT_NXT(a_frame_end_pos, clock, reset, req_accept && req_if.frame_end, pos_ff == '0)
   // Forwarding is armed only while the work stage holds an element.
   `IAF_ASSERT_IMP(a_fwd_needs_s1, clock, reset, fwd_ff && !$past(reset), s1_valid_ff)

endmodule
`default_nettype wire

// ===== verif/tb_integrate_and_fire_aggregator.sv =====
// Self-checking testbench of the integrate-and-fire aggregator with its own prediction of the tokens.
`default_nettype none
module tb_integrate_and_fire_aggregator;
   timeunit 1ns;
   timeprecision 1ps;

   import iaf_pkg::*;

   // Fixed-point landmarks of the scheme. The integral is Q2.15 and is
   // clamped to a 17-bit signed range; sums are clamped to 32 bits.
   localparam int         UNITY         = 32768;
   localparam int         INTEGRAL_HIGH = 65535;
   localparam int         INTEGRAL_LOW  = -65536;
   localparam longint     SUM_HIGH      = 64'sd2147483647;
   localparam longint     SUM_LOW       = -64'sd2147483648;
   localparam value_type  VALUE_MAX     = 16'sh7FFF;
   localparam value_type  VALUE_MIN     = 16'sh8000;
   localparam weight_type WEIGHT_FULL   = 16'hFFFF;

   // Cycles that the receiver refuses tokens during the pressure phase,
   // cycles of quiet after the last expected token, and the overall limit.
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int TIMEOUT_NS    = 5_000_000;

   typedef struct {
      weight_type weight;
      value_type  value;
      logic       frame_end;
   } element_item_type;

   typedef struct {
      sum_type sum;
      logic    token_end;
   } token_word_type;

   logic clock = 1'b0;
   logic reset;

   iaf_req_if req_ch ();
   iaf_rsp_if rsp_ch ();
   iaf_csr_if csr_ch ();

   integrate_and_fire_aggregator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #4 clock = ~clock;

   // Elements waiting to be offered, and token words predicted but not yet seen.
   element_item_type pending_elements [$];
   token_word_type   expected_tokens [$];
   element_item_type current_item;

   // The predictor's own copy of the block's state and of its threshold.
   weight_type    threshold_level = weight_type'(UNITY);
   integral_type  integral_level  = '0;
   sum_type       acc_store [HIDDEN_SIZE];
   int            frame_slot      = 0;
   bit            token_active    = 1'b0;
   part_type      used_frac       = '0;
   part_type      carry_frac      = '0;

   // Handshake shaping: random gaps on or off, the long receiver hold, and
   // the counters that each side keeps for its own gaps.
   bit idle_enabled      = 1'b0;
   bit long_hold_request = 1'b0;
   int source_gap        = 0;
   int sink_stall        = 0;
   int mismatch_count    = 0;

   task automatic note_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic sum_type clamp_sum(input longint raw);
      if (raw > SUM_HIGH) begin
         return sum_type'(SUM_HIGH);
      end else if (raw < SUM_LOW) begin
         return sum_type'(SUM_LOW);
      end
      return sum_type'(raw);
   endfunction

   // Advances the predicted state by one accepted element. The frame's
   // weight is read only at its first element, where the fire decision is
   // taken; a firing frame emits one token word per element and restarts
   // each entry it visits with the part of the weight that carries over.
   function automatic void predict_element(input element_item_type e);
      int             slot;
      int             old_level;
      int             new_level;
      longint         running;
      token_word_type word;
      slot = frame_slot;
      if (slot == 0) begin
         old_level    = int'(integral_level);
         new_level    = old_level + int'(e.weight);
         token_active = (new_level >= int'(threshold_level));
         if (token_active) begin
            new_level  = new_level - UNITY;
            used_frac  = part_type'(UNITY - old_level);
            carry_frac = part_type'(int'(e.weight) - (UNITY - old_level));
         end else begin
            used_frac  = part_type'(int'(e.weight));
            carry_frac = '0;
         end
         if (new_level > INTEGRAL_HIGH) begin
            new_level = INTEGRAL_HIGH;
         end
         if (new_level < INTEGRAL_LOW) begin
            new_level = INTEGRAL_LOW;
         end
         integral_level = integral_type'(new_level);
      end
      running = longint'(acc_store[slot]) + longint'(used_frac) * longint'(e.value);
      if (token_active) begin
         word.sum       = clamp_sum(running);
         word.token_end = e.frame_end;
         expected_tokens.push_back(word);
         acc_store[slot] = clamp_sum(longint'(carry_frac) * longint'(e.value));
      end else begin
         acc_store[slot] = clamp_sum(running);
      end
      // A frame ends at its mark or after the last hidden element.
      if (e.frame_end || slot + 1 >= HIDDEN_SIZE) begin
         frame_slot = 0;
      end else begin
         frame_slot = slot + 1;
      end
   endfunction

   function automatic weight_type pick_weight();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return weight_type'($urandom_range(0, UNITY));
         4:          return weight_type'($urandom_range(0, 2048));
         5:          return weight_type'($urandom_range(30000, UNITY));
         6:          return weight_type'(UNITY);
         7:          return '0;
         8:          return weight_type'($urandom);
         default:    return weight_type'($urandom_range(16000, 17000));
      endcase
   endfunction

   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         6:       return VALUE_MAX;
         7:       return VALUE_MIN;
         8:       return value_type'($urandom_range(0, 512) - 256);
         9:       return '0;
         default: return value_type'($urandom);
      endcase
   endfunction

   task automatic queue_element(input weight_type w, input value_type v, input bit last);
      element_item_type e;
      e.weight    = w;
      e.value     = v;
      e.frame_end = last;
      pending_elements.push_back(e);
   endtask

   // Random frames, mostly short and well formed. About one frame in ten
   // changes its weight after the first element, and about one in ten
   // drops its end mark so that it runs on into the next frame.
   task automatic queue_random_frames(input int item_budget);
      int         length;
      int         style;
      weight_type w;
      while (item_budget > 0) begin
         style  = $urandom_range(0, 9);
         length = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         w      = pick_weight();
         for (int k = 0; k < length; k++) begin
            queue_element((style == 0 && k != 0) ? weight_type'($urandom) : w,
                          pick_value(), (k == length - 1) && (style != 1));
         end
         item_budget -= length;
      end
   endtask

   // Returns once every element has been taken, every predicted token has
   // arrived, and a settling wait has passed, so that the block is idle.
   task automatic wait_until_drained();
      do begin
         @(posedge clock);
      end while (pending_elements.size() != 0 || req_ch.valid
                 || expected_tokens.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One threshold write; the predictor takes the new level at the same
   // edge as the block does.
   task automatic write_threshold(input weight_type level);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= level;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      threshold_level = level;
      csr_ch.valid <= 1'b0;
   endtask

   // Driver: offers the queued elements, holding each until it is taken,
   // and feeds every accepted transaction to the predictor.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         source_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_element(current_item);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (source_gap > 0) begin
               source_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_elements.size() != 0) begin
               current_item = pending_elements.pop_front();
               req_ch.weight    <= current_item.weight;
               req_ch.value     <= current_item.value;
               req_ch.frame_end <= current_item.frame_end;
               req_ch.valid     <= 1'b1;
               if (idle_enabled) begin
                  source_gap = draw_gap();
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready most of the time, with random stalls when gaps are
   // enabled, and one long hold on request that lets the block back up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_stall = 0;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         sink_stall = LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (sink_stall > 0) begin
         sink_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (idle_enabled) begin
            sink_stall = draw_gap();
         end
      end
   end

   // Monitor: every token transaction is checked against the oldest
   // prediction, field by field.
   always @(posedge clock) begin
      token_word_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_tokens.size() == 0) begin
            note_mismatch($sformatf("token word with nothing expected, sum %0d",
                                    rsp_ch.sum));
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_ch.sum !== want.sum) begin
               note_mismatch($sformatf("sum %0d, expected %0d", rsp_ch.sum, want.sum));
            end
            if (rsp_ch.token_end !== want.token_end) begin
               note_mismatch($sformatf("token_end %b, expected %b",
                                       rsp_ch.token_end, want.token_end));
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.weight    = '0;
      req_ch.value     = '0;
      req_ch.frame_end = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.data      = '0;
      foreach (acc_store[k]) begin
         acc_store[k] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Threshold at 1.0. A zero weight never fires; a full unit fires at
      // once, and a changed weight on a later element must be ignored.
      // Three frames of the largest weight drive the integral into its
      // upper clamp, after which the used part turns negative.
      write_threshold(weight_type'(UNITY));
      idle_enabled = 1'b1;
      queue_element('0, VALUE_MAX, 1'b1);
      queue_element(weight_type'(UNITY), VALUE_MIN, 1'b0);
      queue_element(16'd1, VALUE_MAX, 1'b1);
      queue_element(WEIGHT_FULL, VALUE_MAX, 1'b1);
      queue_element(WEIGHT_FULL, VALUE_MIN, 1'b1);
      queue_element(WEIGHT_FULL, 16'sd12345, 1'b1);
      queue_element('0, VALUE_MAX, 1'b1);
      queue_element(16'd16384, 16'sd1, 1'b0);
      queue_element(16'd16384, -16'sd1, 1'b0);
      queue_element(16'd16384, 16'sd256, 1'b0);
      queue_element(16'd16384, -16'sd256, 1'b1);
      queue_random_frames(80);
      wait_until_drained();

      // Threshold at zero, no gaps. A fire leaves the integral negative,
      // so the next fire uses more than a whole unit and the sums clamp
      // at both ends of the 32-bit range.
      write_threshold('0);
      idle_enabled = 1'b0;
      queue_element('0, VALUE_MIN, 1'b1);
      queue_element(weight_type'(UNITY), VALUE_MAX, 1'b1);
      queue_element(weight_type'(UNITY), VALUE_MIN, 1'b1);
      queue_random_frames(50);
      wait_until_drained();

      // Highest possible threshold: fires are rare and sums build up.
      write_threshold(WEIGHT_FULL);
      idle_enabled = 1'b1;
      queue_random_frames(40);
      wait_until_drained();

      write_threshold(weight_type'($urandom_range(1, UNITY - 1)));
      queue_random_frames(40);
      wait_until_drained();

      // Every unit-weight frame fires while the integral is not negative. The
      // receiver holds off for a long stretch while the driver keeps offering,
      // so the block must stall its input; the test then waits until every token has come.
      write_threshold(weight_type'(UNITY));
      idle_enabled      = 1'b0;
      long_hold_request = 1'b1;
      while (pending_elements.size() < 60) begin
         int frame_len;
         frame_len = $urandom_range(4, 12);
         for (int k = 0; k < frame_len; k++) begin
            queue_element(weight_type'(UNITY), pick_value(), k == frame_len - 1);
         end
      end
      wait_until_drained();

      // A frame of exactly the hidden size, then one that runs past it
      // without a mark, so the position wraps and a new frame starts.
      for (int k = 0; k < HIDDEN_SIZE; k++) begin
         queue_element(16'd20000, pick_value(), k == HIDDEN_SIZE - 1);
      end
      for (int k = 0; k < HIDDEN_SIZE + 4; k++) begin
         queue_element(16'd20000, pick_value(), k == HIDDEN_SIZE + 3);
      end
      wait_until_drained();

      write_threshold(weight_type'($urandom_range(0, UNITY)));
      idle_enabled = 1'b1;
      queue_random_frames(40);
      wait_until_drained();

      if (expected_tokens.size() != 0) begin
         note_mismatch($sformatf("%0d token words never arrived", expected_tokens.size()));
      end
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
